// ===== src/srgb8_to_linear16_matrix_assert.svh =====
// Assertion macros for the checker of the sRGB decode block.
`ifndef SRGB8_TO_LINEAR16_MATRIX_ASSERT_SVH
`define SRGB8_TO_LINEAR16_MATRIX_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define SRGBM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, switched off while reset is held.
`define SRGBM_ASSERT_NEXT(label, clk, ante, cons, rst) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

// Next-cycle implication that stays live through reset.
`define SRGBM_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: check across reset failed");

`endif

// ===== src/srgbm_pkg.sv =====
// Package of the sRGB decode block: widths, register indexes and the decoding curve.
package srgbm_pkg;

  localparam int CHAN_IN_W  = 8;
  localparam int CHAN_OUT_W = 16;
  localparam int LUT_DEPTH  = 256;
  localparam int COEF_W     = 20;
  localparam int COEFS_PER_ROW = 3;
  localparam int ROW_W      = COEF_W * COEFS_PER_ROW;
  localparam int CFG_IDX_W  = 2;
  localparam int PIPE_DEPTH = 5;

  localparam logic [CHAN_OUT_W-1:0] ALPHA_OPAQUE = 16'hFFFF;

  // Identity matrix with sixteen fraction bits.
  localparam logic [ROW_W-1:0] ROW_RED_RESET   = 60'h0000000_0001_0000;
  localparam logic [ROW_W-1:0] ROW_GREEN_RESET = 60'h0000010_0000_0000;
  localparam logic [ROW_W-1:0] ROW_BLUE_RESET  = 60'h1000000_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_RED   = 2'd0,
    REG_ROW_GREEN = 2'd1,
    REG_ROW_BLUE  = 2'd2
  } reg_index_t;

  // One word of the sRGB decoding curve with frac_bits fraction bits, worked
  // out at elaboration. The linear segment is exact integer rounding; the
  // power segment rounds half up, and its last code is exactly one.
  function automatic logic [31:0] lin_entry(input int code, input int frac_bits);
    real    base;
    real    lin;
    longint one;
    longint word;
    one = longint'(1) << frac_bits;
    if (code <= 10) begin
      word = (one * 10 * code + 16473) / 32946;
    end else begin
      base = (real'(code) + 14.025) / 269.025;
      lin  = base ** 2.4;
      word = longint'(lin * real'(one));
      if (word > one) begin
        word = one;
      end
    end
    return word[31:0];
  endfunction

endpackage

// ===== src/srgbm_channels.sv =====
// Handshake channels for the sRGB input pixel and the linear output pixel.
interface srgbm_pix_in_if;
  logic                             valid;
  logic                             ready;
  logic [srgbm_pkg::CHAN_IN_W-1:0]  red_in;
  logic [srgbm_pkg::CHAN_IN_W-1:0]  green_in;
  logic [srgbm_pkg::CHAN_IN_W-1:0]  blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface

interface srgbm_pix_out_if;
  logic                             valid;
  logic                             ready;
  logic [srgbm_pkg::CHAN_OUT_W-1:0] red_out;
  logic [srgbm_pkg::CHAN_OUT_W-1:0] green_out;
  logic [srgbm_pkg::CHAN_OUT_W-1:0] blue_out;
  logic [srgbm_pkg::CHAN_OUT_W-1:0] alpha_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output alpha_out, input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  input alpha_out, output ready);
endinterface

// ===== src/srgb8_to_linear16_matrix.sv =====
// Top level of the sRGB to linear decode block with a 3x3 colour matrix.
//
// Usage. Pixels arrive on pix_in as three sRGB bytes and leave on pix_out as
// three 16-bit linear channels plus an alpha word that is always fully opaque.
// A word moves on either channel at a rising edge with valid and ready high.
// Each byte is decoded through a constant 256-word curve table, the three
// linear values go through the matrix held in three row registers, and each
// row result is clamped to the range zero to one and scaled to 16 bits.
//
// Timing. The pipeline has five register stages: input, curve table, the
// products, the clamped sum and the result register. A word accepted at one
// edge passes through them in that order before it is offered on pix_out, and
// one word per cycle is taken for as long as the receiver keeps up; the
// products of each row stage come from combinational multipliers.
//
// Stalls. The whole pipeline advances together. While the result register
// is full and pix_out.ready is low, every stage holds and pix_in.ready is low.
//
// Reset. rst is synchronous; it empties the pipeline and loads the identity
// matrix. The user writes the rows through cfg_write, cfg_index and cfg_data
// only while no pixel is in flight, not enforced; an index past blue is ignored.
module srgb8_to_linear16_matrix #(
  parameter int LINEAR_FRAC_BITS = 20,
  parameter int COEFF_FRAC_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [srgbm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [srgbm_pkg::ROW_W-1:0]     cfg_data,
  srgbm_pix_in_if.sink                    pix_in,
  srgbm_pix_out_if.source                 pix_out
);

  localparam int LinW = LINEAR_FRAC_BITS + 1;

  logic [srgbm_pkg::PIPE_DEPTH-1:0] stage_valid;
  logic                             advance;
  logic                             accept;

  logic [srgbm_pkg::ROW_W-1:0] row_red;
  logic [srgbm_pkg::ROW_W-1:0] row_green;
  logic [srgbm_pkg::ROW_W-1:0] row_blue;

  logic [srgbm_pkg::CHAN_IN_W-1:0] red_q;
  logic [srgbm_pkg::CHAN_IN_W-1:0] green_q;
  logic [srgbm_pkg::CHAN_IN_W-1:0] blue_q;

  logic [LinW-1:0] lin_red;
  logic [LinW-1:0] lin_green;
  logic [LinW-1:0] lin_blue;

  logic [srgbm_pkg::CHAN_OUT_W-1:0] red_res;
  logic [srgbm_pkg::CHAN_OUT_W-1:0] green_res;
  logic [srgbm_pkg::CHAN_OUT_W-1:0] blue_res;

  // Every stage moves on when the result register is empty or being taken.
  assign advance      = !stage_valid[srgbm_pkg::PIPE_DEPTH-1] || pix_out.ready;
  assign accept       = pix_in.valid && advance;
  assign pix_in.ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else if (advance) begin
      stage_valid <= {stage_valid[srgbm_pkg::PIPE_DEPTH-2:0], accept};
    end
  end

  // Matrix rows; the user must write them only while the pipeline is empty, which the block does not enforce.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_red   <= srgbm_pkg::ROW_RED_RESET;
      row_green <= srgbm_pkg::ROW_GREEN_RESET;
      row_blue  <= srgbm_pkg::ROW_BLUE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        srgbm_pkg::REG_ROW_RED:   row_red   <= cfg_data;
        srgbm_pkg::REG_ROW_GREEN: row_green <= cfg_data;
        srgbm_pkg::REG_ROW_BLUE:  row_blue  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register; its contents only matter when the first stage is valid.
  always_ff @(posedge clk) begin
    if (advance) begin
      red_q   <= pix_in.red_in;
      green_q <= pix_in.green_in;
      blue_q  <= pix_in.blue_in;
    end
  end

  srgbm_lut #(.LINEAR_FRAC_BITS(LINEAR_FRAC_BITS)) u_lut_red (
    .clk(clk), .en(advance), .code(red_q), .lin(lin_red)
  );

  srgbm_lut #(.LINEAR_FRAC_BITS(LINEAR_FRAC_BITS)) u_lut_green (
    .clk(clk), .en(advance), .code(green_q), .lin(lin_green)
  );

  srgbm_lut #(.LINEAR_FRAC_BITS(LINEAR_FRAC_BITS)) u_lut_blue (
    .clk(clk), .en(advance), .code(blue_q), .lin(lin_blue)
  );

  srgbm_row #(
    .LINEAR_FRAC_BITS(LINEAR_FRAC_BITS),
    .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
  ) u_row_red (
    .clk(clk), .en(advance), .row(row_red),
    .lin_red(lin_red), .lin_green(lin_green), .lin_blue(lin_blue),
    .chan(red_res)
  );

  srgbm_row #(
    .LINEAR_FRAC_BITS(LINEAR_FRAC_BITS),
    .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
  ) u_row_green (
    .clk(clk), .en(advance), .row(row_green),
    .lin_red(lin_red), .lin_green(lin_green), .lin_blue(lin_blue),
    .chan(green_res)
  );

  srgbm_row #(
    .LINEAR_FRAC_BITS(LINEAR_FRAC_BITS),
    .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
  ) u_row_blue (
    .clk(clk), .en(advance), .row(row_blue),
    .lin_red(lin_red), .lin_green(lin_green), .lin_blue(lin_blue),
    .chan(blue_res)
  );

  assign pix_out.valid     = stage_valid[srgbm_pkg::PIPE_DEPTH-1];
  assign pix_out.red_out   = red_res;
  assign pix_out.green_out = green_res;
  assign pix_out.blue_out  = blue_res;
  assign pix_out.alpha_out = srgbm_pkg::ALPHA_OPAQUE;

endmodule

// ===== src/srgbm_lut.sv =====
// Constant decoding-curve lookup with a registered read.
module srgbm_lut #(
  parameter int LINEAR_FRAC_BITS = 20
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic [srgbm_pkg::CHAN_IN_W-1:0] code,
  output logic [LINEAR_FRAC_BITS:0]       lin
);

  localparam int LinW = LINEAR_FRAC_BITS + 1;

  logic [LinW-1:0] lut_words [srgbm_pkg::LUT_DEPTH];

  for (genvar c = 0; c < srgbm_pkg::LUT_DEPTH; c++) begin : g_word
    localparam logic [31:0] Word = srgbm_pkg::lin_entry(c, LINEAR_FRAC_BITS);
    assign lut_words[c] = Word[LinW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lin <= lut_words[code];
    end
  end

endmodule

// ===== src/srgbm_row.sv =====
// One matrix row: three products, clamped sum, then scaling to 16 bits.
module srgbm_row #(
  parameter int LINEAR_FRAC_BITS = 20,
  parameter int COEFF_FRAC_BITS  = 16
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic [srgbm_pkg::ROW_W-1:0]      row,
  input  logic [LINEAR_FRAC_BITS:0]        lin_red,
  input  logic [LINEAR_FRAC_BITS:0]        lin_green,
  input  logic [LINEAR_FRAC_BITS:0]        lin_blue,
  output logic [srgbm_pkg::CHAN_OUT_W-1:0] chan
);

  localparam int LinW   = LINEAR_FRAC_BITS + 1;
  localparam int MulW   = srgbm_pkg::COEF_W + LinW + 1;
  localparam int SumW   = MulW + 2;
  localparam int ShiftN = LINEAR_FRAC_BITS + COEFF_FRAC_BITS;
  localparam int ClampW = ShiftN + 1;
  localparam int ScaleW = ClampW + srgbm_pkg::CHAN_OUT_W;

  localparam logic signed [SumW-1:0] SumOne   = SumW'(1) << ShiftN;
  localparam logic [ClampW-1:0]      ClampOne = ClampW'(1) << ShiftN;
  localparam logic [ScaleW-1:0]      Half     = ScaleW'(1) << (ShiftN - 1);

  logic [LinW-1:0]          lin_k   [srgbm_pkg::COEFS_PER_ROW];
  logic signed [MulW-1:0]   prod_next [srgbm_pkg::COEFS_PER_ROW];
  logic signed [MulW-1:0]   prod    [srgbm_pkg::COEFS_PER_ROW];
  logic signed [SumW-1:0]   sum;
  logic [ClampW-1:0]        clamped_next;
  logic [ClampW-1:0]        clamped;
  logic [ScaleW-1:0]        scaled;

  assign lin_k[0] = lin_red;
  assign lin_k[1] = lin_green;
  assign lin_k[2] = lin_blue;

  for (genvar k = 0; k < srgbm_pkg::COEFS_PER_ROW; k++) begin : g_mul
    logic signed [srgbm_pkg::COEF_W-1:0] coef;
    logic signed [MulW-1:0]              coef_ext;
    logic signed [MulW-1:0]              lin_ext;
    assign coef      = $signed(row[k*srgbm_pkg::COEF_W +: srgbm_pkg::COEF_W]);
    assign coef_ext  = MulW'(coef);
    assign lin_ext   = $signed(MulW'(lin_k[k]));
    assign prod_next[k] = coef_ext * lin_ext;
  end

  // The full sum cannot overflow: two guard bits cover three products.
  assign sum = SumW'(prod[0]) + SumW'(prod[1]) + SumW'(prod[2]);

  always_comb begin
    if (sum < 0) begin
      clamped_next = '0;
    end else if (sum > SumOne) begin
      clamped_next = ClampOne;
    end else begin
      clamped_next = sum[ClampW-1:0];
    end
  end

  // Times 65535 as a shift and subtract, then round half up.
  assign scaled = (ScaleW'(clamped) << srgbm_pkg::CHAN_OUT_W) - ScaleW'(clamped) + Half;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < srgbm_pkg::COEFS_PER_ROW; k++) begin
        prod[k] <= prod_next[k];
      end
      clamped <= clamped_next;
      chan    <= scaled[ShiftN +: srgbm_pkg::CHAN_OUT_W];
    end
  end

endmodule

// ===== src/srgbm_checker.sv =====
// Port-level checker for the sRGB decode block, bound to the top level.
`include "srgb8_to_linear16_matrix_assert.svh"

module srgbm_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [srgbm_pkg::CHAN_OUT_W-1:0] out_red,
  input logic [srgbm_pkg::CHAN_OUT_W-1:0] out_green,
  input logic [srgbm_pkg::CHAN_OUT_W-1:0] out_blue,
  input logic [srgbm_pkg::CHAN_OUT_W-1:0] out_alpha
);

  // A stalled result word stays offered and unchanged.
  `SRGBM_ASSERT_NEXT(a_stall_hold, clk, out_valid && !out_ready, out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue), rst)

  // The input side is held off exactly when a full result register is not taken.
  `SRGBM_ASSERT_NOW(a_ready_follows_output, clk, rst, in_valid || !in_valid, in_ready == (!out_valid || out_ready))

  // Reset empties the pipeline.
  `SRGBM_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid)

  // Alpha is fully opaque on every result word.
  `SRGBM_ASSERT_NOW(a_alpha_opaque, clk, rst, out_valid, out_alpha == srgbm_pkg::ALPHA_OPAQUE)

endmodule

bind srgb8_to_linear16_matrix srgbm_checker u_srgbm_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (pix_in.valid),
  .in_ready (pix_in.ready),
  .out_valid(pix_out.valid),
  .out_ready(pix_out.ready),
  .out_red  (pix_out.red_out),
  .out_green(pix_out.green_out),
  .out_blue (pix_out.blue_out),
  .out_alpha(pix_out.alpha_out)
);

// ===== tb/tb_srgb8_to_linear16_matrix.sv =====
// Self-checking testbench of the sRGB to linear decode block with its 3x3 colour matrix.

// Keeps the matrix as last written, predicts each linear pixel word and checks the output.
class linear_pixel_tracker;
  localparam int LIN_FRAC = 20;
  localparam int MIX_FRAC = 16;

  typedef bit [383:0] big_t;
  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha;
  } lin_pixel_t;

  logic [LIN_FRAC:0]           curve [256];
  logic [srgbm_pkg::ROW_W-1:0] rows [3];
  lin_pixel_t                  expected_pixels [$];
  int                          mismatches;
  int                          words_checked;

  function new();
    rows[0]       = srgbm_pkg::ROW_RED_RESET;
    rows[1]       = srgbm_pkg::ROW_GREEN_RESET;
    rows[2]       = srgbm_pkg::ROW_BLUE_RESET;
    mismatches    = 0;
    words_checked = 0;
    build_curve();
  endfunction

  // The power segment is found by bisection on an exact integer inequality, so the
  // table is rounded half up without any floating point.
  function void build_curve();
    big_t    denom12;
    big_t    bound;
    big_t    odd;
    big_t    lhs;
    longint  lo;
    longint  hi;
    longint  mid;
    int      i;
    int      c;
    denom12 = big_t'(1);
    for (i = 0; i < 12; i++) begin
      denom12 = denom12 * big_t'(269025);
    end
    for (c = 0; c < 256; c++) begin
      if (c <= 10) begin
        curve[c] = (LIN_FRAC + 1)'(((longint'(1) << LIN_FRAC) * 10 * c + 16473) / 32946);
      end else begin
        bound = big_t'(1);
        for (i = 0; i < 12; i++) begin
          bound = bound * big_t'(1000 * c + 14025);
        end
        bound = bound << (5 * LIN_FRAC + 5);
        lo = 0;
        hi = longint'(1) << LIN_FRAC;
        while (lo < hi) begin
          mid = lo + (hi - lo + 1) / 2;
          odd = big_t'(2 * mid - 1);
          lhs = odd * odd * odd * odd * odd * denom12;
          if (lhs <= bound) begin
            lo = mid;
          end else begin
            hi = mid - 1;
          end
        end
        curve[c] = lo[LIN_FRAC:0];
      end
    end
  endfunction

  function void set_row(input logic [srgbm_pkg::CFG_IDX_W-1:0] idx,
                        input logic [srgbm_pkg::ROW_W-1:0] value);
    case (idx)
      srgbm_pkg::REG_ROW_RED: begin
        rows[0] = value;
      end
      srgbm_pkg::REG_ROW_GREEN: begin
        rows[1] = value;
      end
      srgbm_pkg::REG_ROW_BLUE: begin
        rows[2] = value;
      end
      default: begin
      end
    endcase
  endfunction

  // One matrix row: exact signed sum, clamped to [0,1], scaled and rounded half up.
  function logic [15:0] mix_row(input logic [srgbm_pkg::ROW_W-1:0] row,
                                input logic [LIN_FRAC:0] l_red,
                                input logic [LIN_FRAC:0] l_green,
                                input logic [LIN_FRAC:0] l_blue);
    logic signed [19:0] coef;
    longint             acc;
    longint             one;
    longint             scaled;
    one  = longint'(1) << (LIN_FRAC + MIX_FRAC);
    coef = row[19:0];
    acc  = longint'(coef) * longint'(l_red);
    coef = row[39:20];
    acc  = acc + longint'(coef) * longint'(l_green);
    coef = row[59:40];
    acc  = acc + longint'(coef) * longint'(l_blue);
    if (acc < 0) begin
      acc = 0;
    end else if (acc > one) begin
      acc = one;
    end
    scaled = (acc * 65535 + (longint'(1) << (LIN_FRAC + MIX_FRAC - 1)))
             >> (LIN_FRAC + MIX_FRAC);
    return scaled[15:0];
  endfunction

  function void note_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    lin_pixel_t px;
    px.red   = mix_row(rows[0], curve[r], curve[g], curve[b]);
    px.green = mix_row(rows[1], curve[r], curve[g], curve[b]);
    px.blue  = mix_row(rows[2], curve[r], curve[g], curve[b]);
    px.alpha = srgbm_pkg::ALPHA_OPAQUE;
    expected_pixels.push_back(px);
  endfunction

  function void check_pixel(input logic [15:0] r, input logic [15:0] g,
                            input logic [15:0] b, input logic [15:0] a);
    lin_pixel_t px;
    words_checked++;
    if (expected_pixels.size() == 0) begin
      $error("output word with no pixel outstanding: %h %h %h %h", r, g, b, a);
      mismatches++;
      return;
    end
    px = expected_pixels.pop_front();
    if (r !== px.red) begin
      $error("red_out: expected %0d, got %0d", px.red, r);
      mismatches++;
    end
    if (g !== px.green) begin
      $error("green_out: expected %0d, got %0d", px.green, g);
      mismatches++;
    end
    if (b !== px.blue) begin
      $error("blue_out: expected %0d, got %0d", px.blue, b);
      mismatches++;
    end
    if (a !== px.alpha) begin
      $error("alpha_out: expected %0d, got %0d", px.alpha, a);
      mismatches++;
    end
  endfunction

  function int pending();
    return expected_pixels.size();
  endfunction
endclass

module tb_srgb8_to_linear16_matrix;

  // Run shape: a directed part, then eight matrix settings with random pixels each.
  localparam int RANDOM_PHASES   = 8;
  localparam int WORDS_PER_PHASE = 250;
  // The receiver holds off once, for this many cycles, after this many output words.
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int HOLD_OFF_AFTER  = 300;
  // Cycles without any word moving on either channel before the run is abandoned.
  localparam int STALL_LIMIT     = 4000;
  // Unit coefficient at sixteen fraction bits.
  localparam int Q_ONE           = 1 << 16;
  // Index just beyond the blue row; writes to it must leave the matrix alone.
  localparam logic [srgbm_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            cfg_write;
  logic [srgbm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [srgbm_pkg::ROW_W-1:0]     cfg_data;

  srgbm_pix_in_if  pix_in ();
  srgbm_pix_out_if pix_out ();

  linear_pixel_tracker tracker;
  int                  burst_left  = 0;
  int                  idle_cycles = 0;

  // Directed pixels: black, white, both ends of the linear segment of the curve,
  // the first code on the power segment, pure primaries and a few mixed values.
  logic [23:0] corner_px [11] = '{
    24'h000000, 24'hFFFFFF, 24'h0A0A0A, 24'h0B0B0B, 24'h010203, 24'hFF0000,
    24'h00FF00, 24'h0000FF, 24'h8040C0, 24'hFEFDFC, 24'h090C64
  };

  srgb8_to_linear16_matrix dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_in    (pix_in),
    .pix_out   (pix_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Packs three Q4.16 coefficients, given as integers, into one row register.
  function automatic logic [srgbm_pkg::ROW_W-1:0] make_row(input int k_red,
                                                           input int k_green,
                                                           input int k_blue);
    logic [srgbm_pkg::COEF_W-1:0] c_red;
    logic [srgbm_pkg::COEF_W-1:0] c_green;
    logic [srgbm_pkg::COEF_W-1:0] c_blue;
    c_red   = k_red[srgbm_pkg::COEF_W-1:0];
    c_green = k_green[srgbm_pkg::COEF_W-1:0];
    c_blue  = k_blue[srgbm_pkg::COEF_W-1:0];
    return {c_blue, c_green, c_red};
  endfunction

  // Either any 60-bit pattern, or coefficients within plus or minus 1.5 so that
  // most sums land inside the unclamped range.
  function automatic logic [srgbm_pkg::ROW_W-1:0] random_row(input bit full_range);
    logic [63:0] w;
    if (full_range) begin
      w = {$urandom(), $urandom()};
      return w[srgbm_pkg::ROW_W-1:0];
    end
    return make_row(int'($urandom_range(0, 196608)) - 98304,
                    int'($urandom_range(0, 196608)) - 98304,
                    int'($urandom_range(0, 196608)) - 98304);
  endfunction

  // Mostly uniform bytes, with a share of codes near the ends and on the linear segment.
  function automatic logic [7:0] random_byte();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: return 8'd0;
          1: return 8'd255;
          2: return 8'd10;
          default: return 8'd11;
        endcase
      end
      1: begin
        return 8'($urandom_range(0, 12));
      end
      default: begin
        return 8'($urandom_range(0, 255));
      end
    endcase
  endfunction

  // Offers one pixel and returns just after the edge at which it is taken. Before a new
  // burst the sender may go quiet for a random gap, so gaps fall at random points.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        pix_in.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    pix_in.valid    <= 1'b1;
    pix_in.red_in   <= r;
    pix_in.green_in <= g;
    pix_in.blue_in  <= b;
    // Inputs only move at rising edges, so ready seen at the falling edge holds
    // through the next rising edge, where the word is taken.
    do @(negedge clk); while (!pix_in.ready);
    @(posedge clk);
  endtask

  // Stops offering, waits for every predicted word to come out and then lets the
  // pipeline settle.
  task automatic wait_drain();
    pix_in.valid <= 1'b0;
    burst_left = 0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (srgbm_pkg::PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [srgbm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [srgbm_pkg::ROW_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    tracker.set_row(idx, value);
  endtask

  // Loads all three rows on back-to-back edges, then a random word to the spare index,
  // which the block must ignore.
  task automatic program_matrix(input logic [srgbm_pkg::ROW_W-1:0] r_row,
                                input logic [srgbm_pkg::ROW_W-1:0] g_row,
                                input logic [srgbm_pkg::ROW_W-1:0] b_row);
    wait_drain();
    write_reg(srgbm_pkg::REG_ROW_RED, r_row);
    write_reg(srgbm_pkg::REG_ROW_GREEN, g_row);
    write_reg(srgbm_pkg::REG_ROW_BLUE, b_row);
    write_reg(REG_SPARE, random_row(1'b1));
    cfg_write <= 1'b0;
  endtask

  // Both channels are watched at the falling edge: a word whose valid and ready are
  // high there moves at the following rising edge. The input side is noted first so
  // that the prediction is always queued before its word can come out.
  always @(negedge clk) begin
    if (!rst) begin
      if (pix_in.valid && pix_in.ready) begin
        tracker.note_pixel(pix_in.red_in, pix_in.green_in, pix_in.blue_in);
      end
      if (pix_out.valid && pix_out.ready) begin
        tracker.check_pixel(pix_out.red_out, pix_out.green_out, pix_out.blue_out,
                            pix_out.alpha_out);
      end
      if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Receiver. It runs in segments of random length, each with its own stall rate, one
  // in two of them never stalling. Once, some way into the random part, it refuses
  // every word for a long stretch while the sender keeps offering, so that the
  // pipeline fills and the input side has to back off.
  initial begin
    int  seg_left;
    int  stall_pct;
    bit  held;
    seg_left  = 0;
    stall_pct = 0;
    held      = 1'b0;
    pix_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && tracker.words_checked >= HOLD_OFF_AFTER) begin
        held = 1'b1;
        pix_out.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(10, 200);
          case ($urandom_range(0, 3))
            0, 1: stall_pct = 0;
            2: stall_pct = 30;
            default: stall_pct = 75;
          endcase
        end
        seg_left--;
        pix_out.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Stimulus and the verdict.
  initial begin
    int p;
    int n;
    tracker = new();
    rst             <= 1'b1;
    cfg_write       <= 1'b0;
    cfg_index       <= srgbm_pkg::REG_ROW_RED;
    cfg_data        <= '0;
    pix_in.valid    <= 1'b0;
    pix_in.red_in   <= '0;
    pix_in.green_in <= '0;
    pix_in.blue_in  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // The identity matrix loaded by reset passes the decoded curve straight through.
    foreach (corner_px[i]) begin
      send_pixel(corner_px[i][23:16], corner_px[i][15:8], corner_px[i][7:0]);
    end

    // Red is doubled, so bright reds saturate at one; green is negated, so it clamps
    // to zero; blue is a blend of all three that can still saturate at one for bright pixels.
    program_matrix(make_row(2 * Q_ONE, 0, 0), make_row(0, -Q_ONE, 0),
                   make_row(Q_ONE / 2, Q_ONE / 2, Q_ONE / 4));
    foreach (corner_px[i]) begin
      send_pixel(corner_px[i][23:16], corner_px[i][15:8], corner_px[i][7:0]);
    end

    for (p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          // Largest positive coefficient everywhere.
          program_matrix({3{20'h7FFFF}}, {3{20'h7FFFF}}, {3{20'h7FFFF}});
        end
        1: begin
          // Most negative coefficient everywhere.
          program_matrix({3{20'h80000}}, {3{20'h80000}}, {3{20'h80000}});
        end
        2: begin
          program_matrix('0, '0, '0);
        end
        3: begin
          // Every bit set: each coefficient is the smallest negative step.
          program_matrix('1, '1, '1);
        end
        4: begin
          // A realistic primaries conversion with rows summing to one.
          program_matrix(make_row(41117, 21581, 2838), make_row(4529, 60263, 744),
                         make_row(1075, 5767, 58694));
        end
        7: begin
          program_matrix(random_row(1'b1), random_row(1'b1), random_row(1'b1));
        end
        default: begin
          program_matrix(random_row(1'b0), random_row(1'b0), random_row(1'b0));
        end
      endcase
      for (n = 0; n < WORDS_PER_PHASE; n++) begin
        send_pixel(random_byte(), random_byte(), random_byte());
      end
    end

    wait_drain();
    if (tracker.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== srgb8_to_linear16_matrix.f =====
+incdir+src
src/srgbm_pkg.sv
src/srgbm_channels.sv
src/srgbm_lut.sv
src/srgbm_row.sv
src/srgb8_to_linear16_matrix.sv
src/srgbm_checker.sv
tb/tb_srgb8_to_linear16_matrix.sv
